FILE: rtl/slip_frame_decoder_macros.svh
// assertion macros shared by the slip frame decoder rtl
// expects clk and rst_n in the scope of use

`ifndef SLIP_FRAME_DECODER_MACROS_SVH
`define SLIP_FRAME_DECODER_MACROS_SVH

// implication checked on the following clock edge
`define SFD_ASSERT_NEXT(label, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error(msg);

// property that holds at every clock edge out of reset
`define SFD_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

`endif

FILE: rtl/sfd_pkg.sv
// shared types, codes and helpers for the slip frame decoder
// no dependencies

package sfd_pkg;

    localparam int unsigned BUFFER_DEPTH = 4096;
    localparam int unsigned INDEX_W      = $clog2(BUFFER_DEPTH);
    localparam int unsigned COUNT_W      = 13;
    localparam int unsigned BYTE_W       = 8;

    localparam logic [BYTE_W-1:0] CODE_END     = 8'hC0;
    localparam logic [BYTE_W-1:0] CODE_ESC     = 8'hDB;
    localparam logic [BYTE_W-1:0] CODE_ESC_END = 8'hDC;
    localparam logic [BYTE_W-1:0] CODE_ESC_ESC = 8'hDD;

    localparam logic [COUNT_W-1:0] MAX_LENGTH_RESET = COUNT_W'(4096);
    localparam logic [COUNT_W-1:0] DEPTH_LIMIT      = COUNT_W'(BUFFER_DEPTH);

    typedef enum logic [2:0] {
        MODE_OUTSIDE = 3'b001,
        MODE_FRAME   = 3'b010,
        MODE_ESCAPE  = 3'b100
    } sfd_mode_t;

    typedef struct packed {
        logic               write_valid;
        logic [INDEX_W-1:0] write_index;
        logic [BYTE_W-1:0]  write_data;
        logic               frame_good;
        logic [COUNT_W-1:0] frame_length;
    } sfd_result_t;

    // limit in force is the smaller of the register and the buffer depth
    function automatic logic [COUNT_W-1:0] active_limit(input logic [COUNT_W-1:0] max_length);
        logic [COUNT_W-1:0] lim;
        lim = max_length;
        if (max_length > DEPTH_LIMIT)
        begin
            lim = DEPTH_LIMIT;
        end
        return lim;
    endfunction

endpackage

FILE: rtl/sfd_decode.sv
// decode state (mode, byte count, error flag) and the per-item result logic
// depends on sfd_pkg and slip_frame_decoder_macros.svh

`include "slip_frame_decoder_macros.svh"

module sfd_decode
    import sfd_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               advance,
    input  logic [BYTE_W-1:0]  rx_byte,
    input  logic [COUNT_W-1:0] limit,
    output sfd_result_t        result
);

    sfd_mode_t          mode_reg,  mode_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic               error_reg, error_next;

    logic               store;
    logic [BYTE_W-1:0]  data;

    always_comb
    begin
        mode_next  = mode_reg;
        count_next = count_reg;
        error_next = error_reg;
        store      = 1'b0;
        data       = rx_byte;
        result     = '0;

        if (rx_byte == CODE_END)
        begin
            if (mode_reg == MODE_OUTSIDE)
            begin
                mode_next  = MODE_FRAME;
                count_next = '0;
                error_next = 1'b0;
            end
            else
            begin
                mode_next = MODE_OUTSIDE;
                if ((count_reg != '0) && !error_reg)
                begin
                    result.frame_good   = 1'b1;
                    result.frame_length = count_reg;
                end
            end
        end
        else
        begin
            case (mode_reg)
                MODE_OUTSIDE:
                begin
                    // bytes between frames are ignored
                end
                MODE_ESCAPE:
                begin
                    mode_next = MODE_FRAME;
                    if (rx_byte == CODE_ESC_END)
                    begin
                        data  = CODE_END;
                        store = 1'b1;
                    end
                    else if (rx_byte == CODE_ESC_ESC)
                    begin
                        data  = CODE_ESC;
                        store = 1'b1;
                    end
                    else
                    begin
                        error_next = 1'b1;
                    end
                end
                default:
                begin
                    if (rx_byte == CODE_ESC)
                    begin
                        mode_next = MODE_ESCAPE;
                    end
                    else
                    begin
                        store = 1'b1;
                    end
                end
            endcase
        end

        if (store)
        begin
            if (count_reg < limit)
            begin
                result.write_valid = 1'b1;
                result.write_index = count_reg[INDEX_W-1:0];
                result.write_data  = data;
                count_next         = count_reg + COUNT_W'(1);
            end
            else
            begin
                error_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_OUTSIDE;
            count_reg <= '0;
            error_reg <= 1'b0;
        end
        else if (advance)
        begin
            mode_reg  <= mode_next;
            count_reg <= count_next;
            error_reg <= error_next;
        end
    end

    `SFD_ASSERT_ALWAYS(a_mode_onehot, $onehot(mode_reg), "decode mode lost its one-hot code")
    `SFD_ASSERT_ALWAYS(a_count_bound, count_reg <= DEPTH_LIMIT, "byte count beyond buffer depth")
    `SFD_ASSERT_NEXT(a_good_closes, advance && result.frame_good, mode_reg == MODE_OUTSIDE, "good frame did not close")
    `SFD_ASSERT_NEXT(a_write_counts, advance && result.write_valid, count_reg == COUNT_W'($past(count_reg) + COUNT_W'(1)), "stored byte not counted")

endmodule

FILE: rtl/slip_frame_decoder.sv
// top level of the slip frame decoder: input register, decode step, result register
// depends on sfd_pkg and sfd_decode

// Decodes a SLIP byte stream one received byte per item. Each accepted item
// gives exactly one result item: possibly a frame buffer write (write_valid,
// index, unescaped data) and, on the END that closes a nonempty error-free
// frame, frame_good with the frame length. One item per cycle is sustained
// while out_stall is low. An item is held in the input register and its result
// is loaded into the result register, which raises out_valid; the single decode
// step lies between those registers. A stalled result holds the input register,
// which then stalls the input. max_length is written through cfg_write and
// cfg_data; the user must write it only while idle (not enforced by the block).
// The limit in force is the smaller of max_length and the 4096-entry buffer depth.

module slip_frame_decoder
    import sfd_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_write,
    input  logic [COUNT_W-1:0] cfg_data,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [BYTE_W-1:0]  rx_byte,
    output logic               out_valid,
    input  logic               out_stall,
    output logic               write_valid,
    output logic [INDEX_W-1:0] write_index,
    output logic [BYTE_W-1:0]  write_data,
    output logic               frame_good,
    output logic [COUNT_W-1:0] frame_length
);

    logic [COUNT_W-1:0] max_length_reg;
    logic               in_full_reg,   in_full_next;
    logic [BYTE_W-1:0]  rx_byte_reg;
    logic               out_valid_reg, out_valid_next;
    sfd_result_t        result_reg,    result_next;

    logic advance;
    logic in_take;

    assign advance  = in_full_reg && (!out_valid_reg || !out_stall);
    assign in_stall = in_full_reg && !advance;
    assign in_take  = in_valid && !in_stall;

    always_comb
    begin
        in_full_next = in_full_reg;
        if (in_take)
        begin
            in_full_next = 1'b1;
        end
        else if (advance)
        begin
            in_full_next = 1'b0;
        end

        out_valid_next = out_valid_reg && out_stall;
        if (advance)
        begin
            out_valid_next = 1'b1;
        end
    end

    sfd_decode u_decode
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .rx_byte (rx_byte_reg),
        .limit   (active_limit(max_length_reg)),
        .result  (result_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_length_reg <= MAX_LENGTH_RESET;
            in_full_reg    <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                max_length_reg <= cfg_data;
            end
            in_full_reg   <= in_full_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            rx_byte_reg <= rx_byte;
        end
        if (advance)
        begin
            result_reg <= result_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign write_valid  = result_reg.write_valid;
    assign write_index  = result_reg.write_index;
    assign write_data   = result_reg.write_data;
    assign frame_good   = result_reg.frame_good;
    assign frame_length = result_reg.frame_length;

endmodule
